// ----- design/dwcc_pkg.sv -----
// Shared types, constants and byte-wise CRC functions for the dual-window CRC unit.
package dwcc_pkg;

  localparam int unsigned DUMP_BYTES = 1024;

  localparam int unsigned OFF_W = 10;
  localparam int unsigned CFG_W = 10;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned END_W = CFG_W + 2;

  localparam logic [15:0] CRC16_POLY = 16'h1021;
  localparam logic [15:0] CRC16_MSB = 16'h8000;
  localparam logic [15:0] CRC16_INIT = 16'h0000;
  localparam logic [31:0] CRC32_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC32_INIT = 32'hFFFFFFFF;
  localparam logic [31:0] CRC32_XOROUT = 32'hFFFFFFFF;

  localparam logic [CFG_W-1:0] CRC16_START_RST = 10'hA0;
  localparam logic [CFG_W-1:0] CRC16_LENGTH_RST = 10'd94;
  localparam logic [CFG_W-1:0] CRC32_START_RST = 10'hE0;
  localparam logic [CFG_W-1:0] CRC32_LENGTH_RST = 10'hD4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CRC16_START  = 3'd0,
    REG_CRC16_LENGTH = 3'd1,
    REG_CRC32_START  = 3'd2,
    REG_CRC32_LENGTH = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] crc16_start;
    logic [CFG_W-1:0] crc16_length;
    logic [CFG_W-1:0] crc32_start;
    logic [CFG_W-1:0] crc32_length;
  } cfg_t;

  typedef struct packed {
    logic [OFF_W-1:0] byte_offset;
    logic [7:0]       data_byte;
    logic             last_byte;
  } item_t;

  // CRC-16/XMODEM, MSB first, one byte
  function automatic logic [15:0] xmodem_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC16_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC16_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // reflected CRC-32, one byte
  function automatic logic [31:0] ieee_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = {1'b0, c[31:1]} ^ CRC32_POLY;
      end else begin
        c = {1'b0, c[31:1]};
      end
    end
    return c;
  endfunction

endpackage

// ----- design/dwcc_if.sv -----
// Valid/ready channel interfaces for input bytes and CRC results.
interface dwcc_in_if;
  logic                          valid;
  logic                          ready;
  logic [dwcc_pkg::OFF_W-1:0]    byte_offset;
  logic [7:0]                    data_byte;
  logic                          last_byte;

  modport source (output valid, output byte_offset, output data_byte, output last_byte,
                  input ready);
  modport sink (input valid, input byte_offset, input data_byte, input last_byte,
                output ready);
endinterface

interface dwcc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] crc16_value;
  logic [31:0] crc32_value;

  modport source (output valid, output crc16_value, output crc32_value, input ready);
  modport sink (input valid, input crc16_value, input crc32_value, output ready);
endinterface

// ----- design/dwcc_cfg_regs.sv -----
// Configuration registers for the two CRC windows.
module dwcc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dwcc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dwcc_pkg::CFG_W-1:0]     cfg_wdata_i,
  output dwcc_pkg::cfg_t                 cfg_o
);

  dwcc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        dwcc_pkg::REG_CRC16_START:  cfg_d.crc16_start = cfg_wdata_i;
        dwcc_pkg::REG_CRC16_LENGTH: cfg_d.crc16_length = cfg_wdata_i;
        dwcc_pkg::REG_CRC32_START:  cfg_d.crc32_start = cfg_wdata_i;
        dwcc_pkg::REG_CRC32_LENGTH: cfg_d.crc32_length = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc16_start <= dwcc_pkg::CRC16_START_RST;
      cfg_q.crc16_length <= dwcc_pkg::CRC16_LENGTH_RST;
      cfg_q.crc32_start <= dwcc_pkg::CRC32_START_RST;
      cfg_q.crc32_length <= dwcc_pkg::CRC32_LENGTH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/dwcc_crc_core.sv -----
// CRC-16 and CRC-32 accumulators with window decode and CRC-16 byte substitution.
module dwcc_crc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  dwcc_pkg::item_t   item_i,
  input  dwcc_pkg::cfg_t    cfg_i,
  output logic [15:0]       crc16_o,
  output logic [31:0]       crc32_o
);

  logic [15:0] crc16_q, crc16_d, crc16_upd;
  logic [31:0] crc32_q, crc32_d, crc32_upd;
  logic [dwcc_pkg::END_W-1:0] off_ext, end16, end32, sub_hi, sub_lo;
  logic in_dump, in16, in32;
  logic [7:0] eff_byte;

  always_comb begin
    off_ext = dwcc_pkg::END_W'(item_i.byte_offset);
    end16 = dwcc_pkg::END_W'(cfg_i.crc16_start) + dwcc_pkg::END_W'(cfg_i.crc16_length);
    end32 = dwcc_pkg::END_W'(cfg_i.crc32_start) + dwcc_pkg::END_W'(cfg_i.crc32_length);
    sub_hi = end16;
    sub_lo = end16 + dwcc_pkg::END_W'(1);
    in_dump = 32'(off_ext) < dwcc_pkg::DUMP_BYTES;
    in16 = in_dump && (item_i.byte_offset >= cfg_i.crc16_start) && (off_ext < end16);
    in32 = in_dump && (item_i.byte_offset >= cfg_i.crc32_start) && (off_ext < end32);

    crc16_upd = in16 ? dwcc_pkg::xmodem_byte(crc16_q, item_i.data_byte) : crc16_q;

    if (off_ext == sub_hi) begin
      eff_byte = crc16_upd[15:8];
    end else if (off_ext == sub_lo) begin
      eff_byte = crc16_upd[7:0];
    end else begin
      eff_byte = item_i.data_byte;
    end

    crc32_upd = in32 ? dwcc_pkg::ieee_byte(crc32_q, eff_byte) : crc32_q;

    crc16_d = crc16_q;
    crc32_d = crc32_q;
    if (fire_i) begin
      if (item_i.last_byte) begin
        crc16_d = dwcc_pkg::CRC16_INIT;
        crc32_d = dwcc_pkg::CRC32_INIT;
      end else begin
        crc16_d = crc16_upd;
        crc32_d = crc32_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc16_q <= dwcc_pkg::CRC16_INIT;
      crc32_q <= dwcc_pkg::CRC32_INIT;
    end else begin
      crc16_q <= crc16_d;
      crc32_q <= crc32_d;
    end
  end

  assign crc16_o = crc16_upd;
  assign crc32_o = crc32_upd ^ dwcc_pkg::CRC32_XOROUT;

endmodule

// ----- design/dual_window_crc_checksum_unit.sv -----
// Top level: input beat register, CRC core and result register.
// Result path: the last-byte beat passes from the input register into the result register,
// and waits in the input register while the result register is full and not being taken.
// Throughput: one byte beat per cycle; the input register only holds when a
// last-byte beat meets a result register still full and not being taken.
// The CRC update of the byte in the input register against the accumulators sets the cycle.
// Reset clears valids, accumulators (CRC-16 zero, CRC-32 all ones) and loads default windows.
module dual_window_crc_checksum_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dwcc_in_if.sink                        in_i,
  dwcc_out_if.source                     res_o,
  input  logic                           cfg_we_i,
  input  logic [dwcc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dwcc_pkg::CFG_W-1:0]     cfg_wdata_i
);

  dwcc_pkg::cfg_t  cfg;
  dwcc_pkg::item_t item_q, item_d;
  logic            stage_vld_q, stage_vld_d;
  logic            out_vld_q, out_vld_d;
  logic [15:0]     crc16_q, crc16_d, crc16_c;
  logic [31:0]     crc32_q, crc32_d, crc32_c;
  logic            fire, in_acc, out_free;

  dwcc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dwcc_crc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (item_q),
    .cfg_i   (cfg),
    .crc16_o (crc16_c),
    .crc32_o (crc32_c)
  );

  assign out_free = !out_vld_q || res_o.ready;
  assign fire = stage_vld_q && (!item_q.last_byte || out_free);
  assign in_i.ready = !stage_vld_q || fire;
  assign in_acc = in_i.valid && in_i.ready;

  always_comb begin
    item_d = item_q;
    stage_vld_d = stage_vld_q;
    if (in_acc) begin
      item_d.byte_offset = in_i.byte_offset;
      item_d.data_byte = in_i.data_byte;
      item_d.last_byte = in_i.last_byte;
      stage_vld_d = 1'b1;
    end else if (fire) begin
      stage_vld_d = 1'b0;
    end

    out_vld_d = out_vld_q;
    crc16_d = crc16_q;
    crc32_d = crc32_q;
    if (out_vld_q && res_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (fire && item_q.last_byte) begin
      out_vld_d = 1'b1;
      crc16_d = crc16_c;
      crc32_d = crc32_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      stage_vld_q <= stage_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    crc16_q <= crc16_d;
    crc32_q <= crc32_d;
  end

  assign res_o.valid = out_vld_q;
  assign res_o.crc16_value = crc16_q;
  assign res_o.crc32_value = crc32_q;

endmodule
